/* src/mfo_pkg.sv */
// Package: shared types, codes and helpers of the message FIFO.
`timescale 1ns / 1ps
package mfo_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int MSG_BYTES_DEF = 8;

	localparam int OP_W      = 2;
	localparam int WORD_W    = 32;
	localparam int PAYLOAD_W = 64;
	localparam int CNT_W     = 4;
	localparam int STATUS_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_POST  = 2'd0,
		OP_READ  = 2'd1,
		OP_PEEK  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_TOOBIG = 2'd2
	} status_t;

	// Command kinds after classification in the front part.
	typedef enum logic [2:0] {
		CMD_POST,
		CMD_BIG,
		CMD_POP,
		CMD_PEEK,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t            kind;
		logic [WORD_W-1:0]    mtype;
		logic [WORD_W-1:0]    mparam;
		logic [PAYLOAD_W-1:0] payload;
		logic [CNT_W-1:0]     nbytes;
		logic [CNT_W-1:0]     npeek;
	} cmd_t;

	typedef struct packed {
		status_t              status;
		logic                 has_message;
		logic [WORD_W-1:0]    type_out;
		logic [WORD_W-1:0]    param_out;
		logic [PAYLOAD_W-1:0] payload_out;
		logic [CNT_W-1:0]     length_out;
		logic [CNT_W-1:0]     occupancy;
		logic                 last;
	} rsp_t;

	// Ones in the low n bytes, all ones from eight bytes up.
	function automatic logic [PAYLOAD_W-1:0] byte_mask(input logic [CNT_W-1:0] n);
		logic [PAYLOAD_W-1:0] m;
		for (int i = 0; i < PAYLOAD_W / 8; i++) begin
			m[8*i +: 8] = (CNT_W'(i) < n) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

	// Final result that carries no message.
	function automatic rsp_t no_msg(input status_t st, input logic [CNT_W-1:0] occ);
		rsp_t r;
		r             = '0;
		r.status      = st;
		r.occupancy   = occ;
		r.last        = 1'b1;
		return r;
	endfunction

endpackage

/* src/mfo_ifs.sv */
// Interfaces: request and result channels of the message FIFO.
`timescale 1ns / 1ps
interface mfo_req_if;
	logic                                valid;
	logic                                ready;
	logic [mfo_pkg::OP_W-1:0]            op;
	logic [mfo_pkg::WORD_W-1:0]          msg_type;
	logic [mfo_pkg::WORD_W-1:0]          msg_param;
	logic [mfo_pkg::PAYLOAD_W-1:0]       payload_in;
	logic [mfo_pkg::CNT_W-1:0]           byte_count;
	logic [mfo_pkg::CNT_W-1:0]           peek_count;

	modport source (output valid, op, msg_type, msg_param, payload_in, byte_count,
		peek_count, input ready);
	modport sink (input valid, op, msg_type, msg_param, payload_in, byte_count,
		peek_count, output ready);
endinterface

interface mfo_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [mfo_pkg::STATUS_W-1:0]        status;
	logic                                has_message;
	logic [mfo_pkg::WORD_W-1:0]          type_out;
	logic [mfo_pkg::WORD_W-1:0]          param_out;
	logic [mfo_pkg::PAYLOAD_W-1:0]       payload_out;
	logic [mfo_pkg::CNT_W-1:0]           length_out;
	logic [mfo_pkg::CNT_W-1:0]           occupancy;
	logic                                last;

	modport source (output valid, status, has_message, type_out, param_out, payload_out,
		length_out, occupancy, last, input ready);
	modport sink (input valid, status, has_message, type_out, param_out, payload_out,
		length_out, occupancy, last, output ready);
endinterface

/* src/mfo_front.sv */
// Front part: accept requests and classify them into commands.
`timescale 1ns / 1ps
module mfo_front #(
	parameter int MSG_BYTES = mfo_pkg::MSG_BYTES_DEF
) (
	mfo_req_if.sink        req,
	input  logic           q_full,
	output logic           push,
	output mfo_pkg::cmd_t  push_cmd
);

	assign req.ready = !q_full;
	assign push      = req.valid && !q_full;

	always_comb begin
		push_cmd         = '0;
		push_cmd.mtype   = req.msg_type;
		push_cmd.mparam  = req.msg_param;
		// keep only the posted bytes, the rest stored as zero
		push_cmd.payload = req.payload_in & mfo_pkg::byte_mask(req.byte_count);
		push_cmd.nbytes  = req.byte_count;
		push_cmd.npeek   = req.peek_count;
		unique case (mfo_pkg::op_t'(req.op))
			mfo_pkg::OP_POST: begin
				push_cmd.kind = (req.byte_count > mfo_pkg::CNT_W'(MSG_BYTES)) ?
					mfo_pkg::CMD_BIG : mfo_pkg::CMD_POST;
			end
			mfo_pkg::OP_READ:  push_cmd.kind = mfo_pkg::CMD_POP;
			mfo_pkg::OP_PEEK:  push_cmd.kind = mfo_pkg::CMD_PEEK;
			mfo_pkg::OP_CLEAR: push_cmd.kind = mfo_pkg::CMD_CLEAR;
			default:           push_cmd.kind = mfo_pkg::CMD_CLEAR;
		endcase
	end

endmodule

/* src/mfo_cmdq.sv */
// Command queue: two-entry buffer between front and back parts.
`timescale 1ns / 1ps
module mfo_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mfo_pkg::cmd_t  push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output mfo_pkg::cmd_t  head_cmd
);

	mfo_pkg::cmd_t ent_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_cmd   = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

endmodule

/* src/mfo_back.sv */
// Back part: message ring, pointers, peek sequencer and result register.
`timescale 1ns / 1ps
module mfo_back #(
	parameter int DEPTH     = mfo_pkg::DEPTH_DEF,
	parameter int MSG_BYTES = mfo_pkg::MSG_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cq_valid,
	input  mfo_pkg::cmd_t  cq_cmd,
	output logic           cq_pop,
	mfo_rsp_if.source      rsp
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PLD_W = 8 * MSG_BYTES;
	localparam int CW    = mfo_pkg::CNT_W;

	typedef enum logic {S_IDLE, S_EMIT} state_t;

	// message ring
	logic [mfo_pkg::WORD_W-1:0] type_mem  [DEPTH];
	logic [mfo_pkg::WORD_W-1:0] param_mem [DEPTH];
	logic [PLD_W-1:0]           pld_mem   [DEPTH];
	logic [CW-1:0]              len_mem   [DEPTH];

	logic [mfo_pkg::WORD_W-1:0] rd_type_q;
	logic [mfo_pkg::WORD_W-1:0] rd_param_q;
	logic [PLD_W-1:0]           rd_pld_q;
	logic [CW-1:0]              rd_len_q;

	state_t          state_q;
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] pk_q;
	logic [CW-1:0]    left_q;
	logic [CW-1:0]    want_q;
	logic [CW-1:0]    occ_q;
	logic             out_valid_q;
	mfo_pkg::rsp_t    out_q;

	logic             out_free;
	logic [PTR_W:0]   held_sum;
	logic [PTR_W-1:0] held;
	logic             empty;
	logic             full;
	logic [PTR_W+CW-1:0] held_x;
	logic [CW-1:0]    peek_n;
	logic             start_fetch;
	logic             rd_en;
	logic [PTR_W-1:0] rd_addr;
	logic             wr_en;
	logic [CW-1:0]    msg_n;
	mfo_pkg::rsp_t    msg_rsp;

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [CW-1:0] occ4(input logic [PTR_W-1:0] x);
		logic [PTR_W+CW-1:0] e;
		e = (PTR_W + CW)'(x);
		return e[CW-1:0];
	endfunction

	always_comb begin
		held_sum = (rp_q > wp_q) ? ({1'b0, wp_q} + (PTR_W + 1)'(DEPTH)) : {1'b0, wp_q};
		held     = PTR_W'(held_sum - {1'b0, rp_q});
		empty    = (rp_q == wp_q);
		full     = (nxt(wp_q) == rp_q);
		held_x   = (PTR_W + CW)'(held);
		peek_n   = (held_x < (PTR_W + CW)'(cq_cmd.npeek)) ? held_x[CW-1:0] : cq_cmd.npeek;
	end

	assign out_free = !out_valid_q || rsp.ready;
	assign cq_pop   = (state_q == S_IDLE) && cq_valid && out_free;
	assign wr_en    = cq_pop && (cq_cmd.kind == mfo_pkg::CMD_POST);

	assign start_fetch = cq_pop && !empty &&
		((cq_cmd.kind == mfo_pkg::CMD_POP) ||
		 ((cq_cmd.kind == mfo_pkg::CMD_PEEK) && (cq_cmd.npeek != '0)));
	assign rd_en   = start_fetch || ((state_q == S_EMIT) && out_free && (left_q > CW'(1)));
	assign rd_addr = (state_q == S_IDLE) ? rp_q : pk_q;

	// Truncate the fetched message to the wanted length.
	always_comb begin
		msg_n               = (want_q < rd_len_q) ? want_q : rd_len_q;
		msg_rsp             = '0;
		msg_rsp.status      = mfo_pkg::ST_OK;
		msg_rsp.has_message = 1'b1;
		msg_rsp.type_out    = rd_type_q;
		msg_rsp.param_out   = (msg_n != '0) ? rd_param_q : '0;
		msg_rsp.payload_out = mfo_pkg::PAYLOAD_W'(rd_pld_q) & mfo_pkg::byte_mask(msg_n);
		msg_rsp.length_out  = msg_n;
		msg_rsp.occupancy   = occ_q;
		msg_rsp.last        = (left_q == CW'(1));
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			type_mem[wp_q]  <= cq_cmd.mtype;
			param_mem[wp_q] <= cq_cmd.mparam;
			pld_mem[wp_q]   <= cq_cmd.payload[PLD_W-1:0];
			len_mem[wp_q]   <= cq_cmd.nbytes;
		end
		if (rd_en) begin
			rd_type_q  <= type_mem[rd_addr];
			rd_param_q <= param_mem[rd_addr];
			rd_pld_q   <= pld_mem[rd_addr];
			rd_len_q   <= len_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rp_q        <= '0;
			wp_q        <= '0;
			pk_q        <= '0;
			left_q      <= '0;
			want_q      <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_free) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cq_pop) begin
						unique case (cq_cmd.kind)
							mfo_pkg::CMD_BIG: begin
								out_valid_q <= 1'b1;
								out_q <= mfo_pkg::no_msg(mfo_pkg::ST_TOOBIG, occ4(held));
							end
							mfo_pkg::CMD_POST: begin
								wp_q        <= nxt(wp_q);
								// drop the oldest message when the ring is full
								if (full) begin
									rp_q <= nxt(rp_q);
								end
								out_valid_q <= 1'b1;
								out_q <= mfo_pkg::no_msg(mfo_pkg::ST_OK,
									full ? occ4(held) : occ4(held + PTR_W'(1)));
							end
							mfo_pkg::CMD_CLEAR: begin
								rp_q        <= '0;
								wp_q        <= '0;
								out_valid_q <= 1'b1;
								out_q       <= mfo_pkg::no_msg(mfo_pkg::ST_OK, '0);
							end
							mfo_pkg::CMD_POP, mfo_pkg::CMD_PEEK: begin
								if (empty) begin
									out_valid_q <= 1'b1;
									out_q <= mfo_pkg::no_msg(mfo_pkg::ST_EMPTY, occ4(held));
								end else if (!start_fetch) begin
									out_valid_q <= 1'b1;
									out_q <= mfo_pkg::no_msg(mfo_pkg::ST_OK, occ4(held));
								end else begin
									state_q <= S_EMIT;
									want_q  <= cq_cmd.nbytes;
									pk_q    <= nxt(rp_q);
									if (cq_cmd.kind == mfo_pkg::CMD_POP) begin
										rp_q   <= nxt(rp_q);
										left_q <= CW'(1);
										occ_q  <= occ4(held - PTR_W'(1));
									end else begin
										left_q <= peek_n;
										occ_q  <= occ4(held);
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= msg_rsp;
						if (left_q == CW'(1)) begin
							state_q <= S_IDLE;
						end else begin
							left_q <= left_q - CW'(1);
							pk_q   <= nxt(pk_q);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.has_message = out_q.has_message;
	assign rsp.type_out    = out_q.type_out;
	assign rsp.param_out   = out_q.param_out;
	assign rsp.payload_out = out_q.payload_out;
	assign rsp.length_out  = out_q.length_out;
	assign rsp.occupancy   = out_q.occupancy;
	assign rsp.last        = out_q.last;

	a_msg_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.has_message |-> out_q.status == mfo_pkg::ST_OK)
		else $error("message result with non-ok status");

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.length_out <= CW'(MSG_BYTES))
		else $error("returned length beyond slot size");

	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.length_out == '0 |->
			out_q.param_out == '0 && out_q.payload_out == '0)
		else $error("zero-length result carries data");

	a_emit_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> left_q != '0)
		else $error("sequencer emitting with nothing left");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= PTR_W'(DEPTH - 1) && wp_q <= PTR_W'(DEPTH - 1) && pk_q <= PTR_W'(DEPTH - 1))
		else $error("ring pointer out of range");

endmodule

/* src/message_fifo_overwrite_oldest.sv */
// Top level: message FIFO that overwrites its oldest message when full.
//
//   port   dir  modport  what one request carries
//   req    in   sink     op, msg_type, msg_param, payload_in, byte_count, peek_count
//   rsp    out  source   status, has_message, type_out, param_out, payload_out,
//                        length_out, occupancy, last
//
// Sequence: post, clear, refused post and empty read/peek set the result directly;
// a read goes through a registered ring read, then the result; a peek of n messages gives
// one result a cycle while the output is free, paced by the single ring read port.
// Path from request to result register: the command queue for results without a
// message, and after it the registered ring read for a read or peek.
// Reset: arst_n clears pointers, queue and result register; the ring itself is not
// cleared, only written slots are ever read.
// Stalls: a held result stops the back part; the queue then fills and drops req.ready.
`timescale 1ns / 1ps
module message_fifo_overwrite_oldest #(
	parameter int DEPTH     = mfo_pkg::DEPTH_DEF,
	parameter int MSG_BYTES = mfo_pkg::MSG_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mfo_req_if.sink   req,
	mfo_rsp_if.source rsp
);

	// front to queue
	logic          push;
	mfo_pkg::cmd_t push_cmd;
	logic          q_full;

	// queue to back
	logic          cq_valid;
	mfo_pkg::cmd_t cq_cmd;
	logic          cq_pop;

	// Classify each request: mark oversized posts for refusal, mask posted bytes.
	mfo_front #(
		.MSG_BYTES (MSG_BYTES)
	) u_front (
		.req      (req),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Decouple acceptance from execution so a stalled result does not block intake
	// until two commands are waiting.
	mfo_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (cq_pop),
		.head_valid (cq_valid),
		.head_cmd   (cq_cmd)
	);

	// Execute commands against the ring and drive the result register.
	mfo_back #(
		.DEPTH     (DEPTH),
		.MSG_BYTES (MSG_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cq_valid (cq_valid),
		.cq_cmd   (cq_cmd),
		.cq_pop   (cq_pop),
		.rsp      (rsp)
	);

endmodule
